// ===== src/bankers_safety_checker_unit_defines.svh =====
// Assertion helpers for the safety checker.
`ifndef BANKERS_SAFETY_CHECKER_UNIT_DEFINES_SVH
`define BANKERS_SAFETY_CHECKER_UNIT_DEFINES_SVH

// Checks that cons holds in the cycle after ante.
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsc assertion failed");

// Checks that cons holds whenever ante holds.
`define BSC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsc assertion failed");

`endif

// ===== src/bsc_pkg.sv =====
package bsc_pkg;

   localparam int DefMaxProcesses = 8;
   localparam int DefMaxResources = 8;
   localparam int DefValueBits    = 16;

   localparam logic [2:0] REQ_LOAD_ALLOC = 3'd0;
   localparam logic [2:0] REQ_LOAD_MAX   = 3'd1;
   localparam logic [2:0] REQ_LOAD_AVAIL = 3'd2;
   localparam logic [2:0] REQ_CHECK      = 3'd3;
   localparam logic [2:0] REQ_ELEMENT    = 3'd4;

   localparam logic [1:0] STS_ACK    = 2'd0;
   localparam logic [1:0] STS_SEQ    = 2'd1;
   localparam logic [1:0] STS_UNSAFE = 2'd2;
   localparam logic [1:0] STS_DENIED = 2'd3;

   localparam logic [0:0] CSR_NUM_PROCESSES = 1'd0;
   localparam logic [0:0] CSR_NUM_RESOURCES = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RCHECK,
      ST_SINIT,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic wr_alloc;
      logic wr_max;
      logic wr_avail;
      logic wr_req;
      logic clear_req;
      logic apply;
      logic load_work;
      logic add_work;
   } cell_ctrl_type;

endpackage

// ===== src/bankers_safety_checker_unit.sv =====
// Banker's algorithm engine built as a row of resource cells, one per resource column.
// A load, a non-final request element or an unused type answers one acknowledge beat
// in the next cycle; busy stays low and the next item may follow at once.
// A safety check tests one process per cycle across all cells (np processes in use),
// with one beat per pick and an unsafe beat if no process fits. A final request element
// first passes a check state: a denied beat, or the request is applied and the safety
// test runs. Result beats cannot be stalled: each stands on the rsp ports for one cycle.
module bankers_safety_checker_unit #(
   parameter int MAX_PROCESSES = bsc_pkg::DefMaxProcesses,
   parameter int MAX_RESOURCES = bsc_pkg::DefMaxResources,
   parameter int VALUE_BITS    = bsc_pkg::DefValueBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_process_index,
   input  logic [2:0]  req_resource_index,
   input  logic [15:0] req_amount,
   input  logic        req_last_element,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_seq_process,
   output logic        rsp_last_result,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_write_data
);
   import bsc_pkg::*;

   `include "bankers_safety_checker_unit_defines.svh"

   localparam int RB  = $clog2(MAX_PROCESSES);
   localparam int PCW = $clog2(MAX_PROCESSES + 1);
   localparam int NRW = $clog2(MAX_RESOURCES + 1);
   localparam int IW  = (RB > 3) ? RB : 3;

   state_type          state_ff, state_in;
   logic [3:0]         np_cfg_ff, nr_cfg_ff;
   logic [RB-1:0]      row_ff, row_in;
   logic [PCW-1:0]     pass_ff, pass_in;
   logic [MAX_PROCESSES-1:0] fin_ff, fin_in;
   logic               bad_row_ff, bad_row_in;
   logic               strobe_ff, strobe_in;
   logic [1:0]         status_ff, status_in;
   logic [2:0]         seq_ff, seq_in;
   logic               last_ff, last_in;

   logic [PCW-1:0]     np;
   logic [NRW-1:0]     nr;
   logic [IW-1:0]      p_ext;
   logic [RB-1:0]      row_sel;
   logic               row_ok;
   logic               accept;
   logic               fit;
   logic [31:0]        amt32;
   logic [VALUE_BITS-1:0] value;
   cell_ctrl_type      ctrl;
   logic [MAX_RESOURCES:0] fits_chain;
   logic [MAX_RESOURCES:0] deny_chain;

   always_comb begin
      int npi, nri;
      npi = int'(np_cfg_ff);
      nri = int'(nr_cfg_ff);
      if (npi == 0) npi = 1;
      if (npi > MAX_PROCESSES) npi = MAX_PROCESSES;
      if (nri == 0) nri = 1;
      if (nri > MAX_RESOURCES) nri = MAX_RESOURCES;
      np = PCW'(npi);
      nr = NRW'(nri);
   end

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign p_ext   = IW'(req_process_index);
   assign row_ok  = int'(req_process_index) < MAX_PROCESSES;
   assign row_sel = busy ? row_ff : p_ext[RB-1:0];
   assign amt32   = 32'(req_amount);
   assign value   = amt32[VALUE_BITS-1:0];
   assign fit     = fits_chain[MAX_RESOURCES] && !fin_ff[row_ff];

   assign fits_chain[0] = 1'b1;
   assign deny_chain[0] = 1'b0;

   for (genvar c = 0; c < MAX_RESOURCES; c++) begin : g_cell
      bsc_cell #(
         .COL(c),
         .MAX_PROCESSES(MAX_PROCESSES),
         .MAX_RESOURCES(MAX_RESOURCES),
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .row(row_sel),
         .col(req_resource_index),
         .value(value),
         .nr(nr),
         .fits_in(fits_chain[c]),
         .deny_in(deny_chain[c]),
         .fits_out(fits_chain[c+1]),
         .deny_out(deny_chain[c+1])
      );
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      pass_in    = pass_ff;
      fin_in     = fin_ff;
      bad_row_in = bad_row_ff;
      strobe_in  = 1'b0;
      status_in  = STS_ACK;
      seq_in     = 3'd0;
      last_in    = 1'b1;
      ctrl       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_LOAD_ALLOC: begin
                     ctrl.wr_alloc = row_ok;
                     strobe_in     = 1'b1;
                  end
                  REQ_LOAD_MAX: begin
                     ctrl.wr_max = row_ok;
                     strobe_in   = 1'b1;
                  end
                  REQ_LOAD_AVAIL: begin
                     ctrl.wr_avail = 1'b1;
                     strobe_in     = 1'b1;
                  end
                  REQ_CHECK: begin
                     state_in = ST_SINIT;
                  end
                  REQ_ELEMENT: begin
                     ctrl.wr_req = 1'b1;
                     if (req_last_element) begin
                        row_in     = p_ext[RB-1:0];
                        bad_row_in = !row_ok;
                        state_in   = ST_RCHECK;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RCHECK: begin
            ctrl.clear_req = 1'b1;
            if (bad_row_ff || deny_chain[MAX_RESOURCES]) begin
               strobe_in = 1'b1;
               status_in = STS_DENIED;
               state_in  = ST_IDLE;
            end else begin
               ctrl.apply = 1'b1;
               state_in   = ST_SINIT;
            end
         end
         ST_SINIT: begin
            ctrl.load_work = 1'b1;
            fin_in   = '0;
            row_in   = '0;
            pass_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (fit) begin
               ctrl.add_work   = 1'b1;
               fin_in[row_ff]  = 1'b1;
               strobe_in       = 1'b1;
               status_in       = STS_SEQ;
               seq_in          = 3'(row_ff);
               last_in         = (pass_ff + 1'b1 == np);
               pass_in         = pass_ff + 1'b1;
               row_in          = '0;
               if (pass_ff + 1'b1 == np) state_in = ST_IDLE;
            end else if (PCW'(row_ff) == np - 1'b1) begin
               strobe_in = 1'b1;
               status_in = STS_UNSAFE;
               state_in  = ST_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         np_cfg_ff  <= 4'd1;
         nr_cfg_ff  <= 4'd1;
         fin_ff     <= '0;
         strobe_ff  <= 1'b0;
         row_ff     <= '0;
         pass_ff    <= '0;
         bad_row_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fin_ff     <= fin_in;
         strobe_ff  <= strobe_in;
         row_ff     <= row_in;
         pass_ff    <= pass_in;
         bad_row_ff <= bad_row_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_NUM_PROCESSES: np_cfg_ff <= csr_write_data;
               CSR_NUM_RESOURCES: nr_cfg_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      seq_ff    <= seq_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_seq_process = seq_ff;
   assign rsp_last_result = last_ff;

   `BSC_ASSERT_NEXT(a_run_ends_with_last, busy && (state_in == ST_IDLE), rsp_strobe && rsp_last_result)
   `BSC_ASSERT_SAME(a_seq_zero_off_pick, rsp_strobe && (rsp_status != STS_SEQ), rsp_seq_process == 3'd0)
   `BSC_ASSERT_SAME(a_picks_bounded, state_ff == ST_SCAN, $countones(fin_ff) <= int'(np))
   `BSC_ASSERT_NEXT(a_no_beat_in_sinit, state_ff == ST_SINIT, !rsp_strobe)

endmodule

// ===== src/bsc_cell.sv =====
module bsc_cell #(
   parameter int COL           = 0,
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 8,
   parameter int VALUE_BITS    = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  bsc_pkg::cell_ctrl_type                      ctrl,
   input  logic [$clog2(MAX_PROCESSES)-1:0]            row,
   input  logic [2:0]                                  col,
   input  logic [VALUE_BITS-1:0]                       value,
   input  logic [$clog2(MAX_RESOURCES+1)-1:0]          nr,
   input  logic                                        fits_in,
   input  logic                                        deny_in,
   output logic                                        fits_out,
   output logic                                        deny_out
);
   import bsc_pkg::*;

   localparam int WB = VALUE_BITS + $clog2(MAX_PROCESSES + 1);

   logic [VALUE_BITS-1:0] alloc_ff [MAX_PROCESSES];
   logic [VALUE_BITS-1:0] max_ff   [MAX_PROCESSES];
   logic [VALUE_BITS-1:0] avail_ff;
   logic [VALUE_BITS-1:0] req_ff;
   logic [WB-1:0]         work_ff;

   logic                         col_hit;
   logic                         en;
   logic signed [VALUE_BITS:0]   need;
   logic signed [WB:0]           need_x;
   logic signed [WB:0]           work_x;
   logic signed [VALUE_BITS:0]   req_x;

   always_comb begin
      col_hit  = (int'(col) == COL);
      en       = (COL < int'(nr));
      need     = signed'({1'b0, max_ff[row]}) - signed'({1'b0, alloc_ff[row]});
      need_x   = (WB+1)'(need);
      work_x   = signed'({1'b0, work_ff});
      req_x    = signed'({1'b0, req_ff});
      fits_out = fits_in && (!en || (need_x <= work_x));
      deny_out = deny_in || (en && ((req_x > need) || (req_ff > avail_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PROCESSES; i++) begin
            alloc_ff[i] <= '0;
            max_ff[i]   <= '0;
         end
         avail_ff <= '0;
         req_ff   <= '0;
         work_ff  <= '0;
      end else begin
         if (ctrl.wr_alloc && col_hit) begin
            alloc_ff[row] <= value;
         end else if (ctrl.apply && en) begin
            alloc_ff[row] <= alloc_ff[row] + req_ff;
         end
         if (ctrl.wr_max && col_hit) begin
            max_ff[row] <= value;
         end
         if (ctrl.wr_avail && col_hit) begin
            avail_ff <= value;
         end else if (ctrl.apply && en) begin
            avail_ff <= avail_ff - req_ff;
         end
         if (ctrl.clear_req) begin
            req_ff <= '0;
         end else if (ctrl.wr_req && col_hit) begin
            req_ff <= value;
         end
         if (ctrl.load_work) begin
            work_ff <= WB'(avail_ff);
         end else if (ctrl.add_work && en) begin
            work_ff <= work_ff + WB'(alloc_ff[row]);
         end
      end
   end

endmodule

// ===== dv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsc_pkg::*;

   typedef struct {
      logic [2:0]  kind;
      logic [2:0]  proc;
      logic [2:0]  res;
      logic [15:0] amount;
      logic        last;
      int          idle_pct;
      bit          drain_first;
   } op_type;

   typedef struct {
      logic [1:0] status;
      logic [2:0] seq_process;
      logic       last_result;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_type = '0;
   logic [2:0]  req_process_index = '0;
   logic [2:0]  req_resource_index = '0;
   logic [15:0] req_amount = '0;
   logic        req_last_element = 1'b0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_seq_process;
   logic        rsp_last_result;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [3:0]  csr_write_data = '0;

   op_type      pending_ops[$];
   outcome_type expected_beats[$];
   int       error_count = 0;
   int       accepted_count = 0;
   int       queued_count = 0;

   logic [3:0]  proc_reg, res_reg;
   logic [15:0] alloc_mem[8][8];
   logic [15:0] max_mem[8][8];
   logic [15:0] avail_mem[8];
   logic [15:0] req_buf[8];

   bankers_safety_checker_unit u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int clamp_count(logic [3:0] v);
      if (v == 0) return 1;
      if (v > 8) return 8;
      return v;
   endfunction

   function automatic void push_beat(logic [1:0] s, logic [2:0] p, logic l);
      outcome_type o;
      o.status = s;
      o.seq_process = p;
      o.last_result = l;
      expected_beats.push_back(o);
   endfunction

   function automatic void predict_safety();
      int np, nr, pick;
      logic [19:0] work[8];
      logic [7:0] done;
      bit fits;
      np = clamp_count(proc_reg);
      nr = clamp_count(res_reg);
      for (int r = 0; r < 8; r++) work[r] = avail_mem[r];
      done = '0;
      for (int pass = 0; pass < np; pass++) begin
         pick = -1;
         for (int p = 0; p < np && pick < 0; p++) begin
            if (done[p]) continue;
            fits = 1;
            for (int r = 0; r < nr; r++) begin
               if (int'(max_mem[p][r]) - int'(alloc_mem[p][r]) > int'(work[r])) begin
                  fits = 0;
                  break;
               end
            end
            if (fits) pick = p;
         end
         if (pick < 0) begin
            push_beat(STS_UNSAFE, 3'd0, 1'b1);
            return;
         end
         done[pick] = 1'b1;
         for (int r = 0; r < nr; r++) work[r] += alloc_mem[pick][r];
         push_beat(STS_SEQ, 3'(pick), pass + 1 == np);
      end
   endfunction

   function automatic void predict_beat(op_type op);
      int nr;
      bit deny;
      case (op.kind)
         REQ_LOAD_ALLOC, REQ_LOAD_MAX, REQ_LOAD_AVAIL: begin
            if (op.kind == REQ_LOAD_ALLOC) alloc_mem[op.proc][op.res] = op.amount;
            if (op.kind == REQ_LOAD_MAX) max_mem[op.proc][op.res] = op.amount;
            if (op.kind == REQ_LOAD_AVAIL) avail_mem[op.res] = op.amount;
            push_beat(STS_ACK, 3'd0, 1'b1);
         end
         REQ_CHECK: predict_safety();
         REQ_ELEMENT: begin
            req_buf[op.res] = op.amount;
            if (!op.last) begin
               push_beat(STS_ACK, 3'd0, 1'b1);
            end else begin
               nr = clamp_count(res_reg);
               deny = 0;
               for (int j = 0; j < nr; j++) begin
                  if (int'(req_buf[j]) > int'(max_mem[op.proc][j]) - int'(alloc_mem[op.proc][j])
                      || req_buf[j] > avail_mem[j]) begin
                     deny = 1;
                     break;
                  end
               end
               if (deny) begin
                  push_beat(STS_DENIED, 3'd0, 1'b1);
               end else begin
                  for (int j = 0; j < nr; j++) begin
                     avail_mem[j] -= req_buf[j];
                     alloc_mem[op.proc][j] += req_buf[j];
                  end
               end
               for (int j = 0; j < 8; j++) req_buf[j] = '0;
               if (!deny) predict_safety();
            end
         end
         default: push_beat(STS_ACK, 3'd0, 1'b1);
      endcase
   endfunction

   function automatic void add_op(logic [2:0] k, logic [2:0] p, logic [2:0] r,
                                  logic [15:0] a, logic l, int idle, bit drain = 0);
      op_type op;
      op.kind = k;
      op.proc = p;
      op.res = r;
      op.amount = a;
      op.last = l;
      op.idle_pct = idle;
      op.drain_first = drain;
      pending_ops.push_back(op);
      queued_count++;
   endfunction

   logic busy_at_edge;
   bit   waiting_drain = 0;
   always @(posedge clock) busy_at_edge <= busy;

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predict_beat(pending_ops.pop_front());
         accepted_count++;
      end
   end

   // Driver: one beat from the queue at a time, with idle gaps.
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy_at_edge) begin
            start <= 1'b0;
         end else if (!start && pending_ops.size() > 0) begin
            if (pending_ops[0].drain_first && expected_beats.size() > 0) begin
               start <= 1'b0;
            end else if ($urandom_range(99) >= pending_ops[0].idle_pct) begin
               start <= 1'b1;
               req_type <= pending_ops[0].kind;
               req_process_index <= pending_ops[0].proc;
               req_resource_index <= pending_ops[0].res;
               req_amount <= pending_ops[0].amount;
               req_last_element <= pending_ops[0].last;
            end
         end
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: status %0d process %0d", rsp_status, rsp_seq_process);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_seq_process !== want.seq_process) begin
               $error("seq_process: expected %0d actual %0d", want.seq_process,
                      rsp_seq_process);
               error_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("last_result: expected %0d actual %0d", want.last_result,
                      rsp_last_result);
               error_count++;
            end
         end
      end
   end

   task automatic write_csr(logic [0:0] idx, logic [3:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_NUM_PROCESSES) proc_reg = val;
      else res_reg = val;
   endtask

   task automatic wait_idle();
      while (pending_ops.size() > 0 || start || expected_beats.size() > 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic void add_request(int idle, int np, int nr, logic [15:0] scale);
      logic [2:0] p;
      p = 3'($urandom_range(np - 1));
      for (int j = 0; j < nr; j++)
         add_op(REQ_ELEMENT, p, 3'(j), 16'($urandom_range(scale)), j == nr - 1, idle);
   endfunction

   function automatic void add_scenario(int idle, int np, int nr);
      logic [15:0] a, m;
      for (int p = 0; p < np; p++)
         for (int r = 0; r < nr; r++) begin
            a = 16'($urandom_range(6));
            m = ($urandom_range(9) == 0) ? 16'($urandom_range(2)) : a + 16'($urandom_range(6));
            add_op(REQ_LOAD_ALLOC, 3'(p), 3'(r), a, 1'($urandom_range(1)), idle);
            add_op(REQ_LOAD_MAX, 3'(p), 3'(r), m, 1'($urandom_range(1)), idle);
         end
      for (int r = 0; r < nr; r++)
         add_op(REQ_LOAD_AVAIL, 3'($urandom_range(7)), 3'(r), 16'($urandom_range(8)), 1'b0,
                idle);
      add_op(REQ_CHECK, 3'($urandom_range(7)), 3'($urandom_range(7)), 16'($urandom),
             1'($urandom_range(1)), idle);
      for (int k = 0; k < 3; k++) add_request(idle, np, nr, 4);
   endfunction

   initial begin
      int idles[4] = '{0, 47, 0, 20};
      int np, nr;
      for (int p = 0; p < 8; p++) begin
         avail_mem[p] = '0;
         req_buf[p] = '0;
         for (int r = 0; r < 8; r++) begin
            alloc_mem[p][r] = '0;
            max_mem[p][r] = '0;
         end
      end
      proc_reg = 4'd1;
      res_reg = 4'd1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_op(REQ_CHECK, 3'd0, 3'd0, 16'd0, 1'b0, 0);
      add_op(REQ_LOAD_ALLOC, 3'd7, 3'd7, 16'hFFFF, 1'b1, 0);
      add_op(REQ_LOAD_MAX, 3'd0, 3'd0, 16'hFFFF, 1'b0, 0);
      add_op(REQ_CHECK, 3'd7, 3'd7, 16'hFFFF, 1'b1, 0);
      add_op(REQ_LOAD_AVAIL, 3'd0, 3'd0, 16'hFFFF, 1'b0, 0);
      add_op(REQ_CHECK, 3'd0, 3'd0, 16'd0, 1'b0, 0);
      add_op(3'd5, 3'd1, 3'd2, 16'h1234, 1'b0, 0);
      add_op(3'd6, 3'd0, 3'd0, 16'd0, 1'b1, 0);
      add_op(3'd7, 3'd7, 3'd7, 16'hFFFF, 1'b1, 0);
      add_op(REQ_ELEMENT, 3'd0, 3'd5, 16'd9, 1'b0, 0);
      add_op(REQ_ELEMENT, 3'd0, 3'd0, 16'h8000, 1'b1, 0);
      add_op(REQ_ELEMENT, 3'd0, 3'd0, 16'd1, 1'b1, 0);
      add_op(REQ_LOAD_ALLOC, 3'd0, 3'd0, 16'hFFFF, 1'b0, 0);
      add_op(REQ_LOAD_MAX, 3'd0, 3'd0, 16'd0, 1'b0, 0);
      add_op(REQ_CHECK, 3'd0, 3'd0, 16'd0, 1'b0, 0, 1);
      wait_idle();
      write_csr(CSR_NUM_PROCESSES, 4'd0);
      write_csr(CSR_NUM_RESOURCES, 4'd15);
      add_op(REQ_CHECK, 3'd0, 3'd0, 16'd0, 1'b0, 0);
      add_op(REQ_ELEMENT, 3'd1, 3'd7, 16'd0, 1'b1, 0);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         np = (ph == 0) ? 8 : (ph == 1) ? 1 : $urandom_range(2, 4);
         nr = (ph == 0) ? 1 : (ph == 1) ? 4 : $urandom_range(1, 2);
         write_csr(CSR_NUM_PROCESSES, (ph == 7) ? 4'd9 : 4'(np));
         write_csr(CSR_NUM_RESOURCES, 4'(nr));
         if (ph == 7) np = 8;
         do begin
            if ($urandom_range(4) == 0)
               add_op(3'($urandom_range(7)), 3'($urandom), 3'($urandom), 16'($urandom),
                      1'($urandom_range(1)), idles[ph % 4], $urandom_range(5) == 0);
            else
               add_scenario(idles[ph % 4], np, nr);
         end while (queued_count < 17 + 18 * (ph + 1));
         wait_idle();
      end

      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb failed");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+src
src/bsc_pkg.sv
src/bsc_cell.sv
src/bankers_safety_checker_unit.sv
dv/tb.sv
